// ----- hw/rtl/lcr_pkg.sv -----
`timescale 1ns / 1ps

package lcr_pkg;

    // Conversion framing
    localparam int DATA_BITS  = 24;
    localparam int BIT_CNT_W  = 5;
    localparam int HALF_W     = 16;
    localparam int WAIT_W     = 32;
    localparam int GAIN_W     = 2;
    localparam int SAMPLES_W  = 8;
    localparam int SCALE_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Arithmetic widths
    localparam int OFFSET_W   = 32;
    localparam int SUM_W      = 32;
    localparam int DIFF_W     = DATA_BITS + 9;     // raw minus a full-width offset
    localparam int ACC_W      = SCALE_W + 2;       // upper half of the serial product
    localparam int PROD_W     = ACC_W + DIFF_W;
    localparam int FRAC_BITS  = 16;
    localparam int WEIGHT_W   = 40;
    localparam int MUL_STEPS  = DIFF_W;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARE_SAMPLES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16     = 3'd4;

    // Register reset values
    localparam logic [GAIN_W-1:0]    RST_GAIN_PULSES   = 2'd1;
    localparam logic [HALF_W-1:0]    RST_HALF_PERIOD   = 16'd10;
    localparam logic [WAIT_W-1:0]    RST_READY_TIMEOUT = 32'd1000000;
    localparam logic [SAMPLES_W-1:0] RST_TARE_SAMPLES  = 8'd10;
    localparam logic [SCALE_W-1:0]   RST_SCALE_Q16     = 32'd65536;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef enum logic [1:0] {
        CT_TICK,
        CT_MUL,
        CT_DIV
    } ctl_t;

endpackage

// ----- hw/rtl/lcr_mul.sv -----
`timescale 1ns / 1ps

// Radix-2 shift-add signed multiplier, one multiplier bit per cycle, with the
// floor shift and 40-bit saturation on the finished product.
module lcr_mul
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [lcr_pkg::SCALE_W-1:0]  scale,
    input  logic signed [lcr_pkg::DIFF_W-1:0]   diff,
    output logic                                done,
    output logic signed [lcr_pkg::WEIGHT_W-1:0] weight
);

    localparam int AW = lcr_pkg::ACC_W;
    localparam int DW = lcr_pkg::DIFF_W;
    localparam int PW = lcr_pkg::PROD_W;
    localparam int LO = lcr_pkg::FRAC_BITS;
    localparam int HI = lcr_pkg::FRAC_BITS + lcr_pkg::WEIGHT_W;

    logic                           busy_reg;
    logic [lcr_pkg::MUL_CNT_W-1:0]  step_reg;
    logic                           done_reg;
    logic [AW-1:0]                  hi_reg;
    logic [DW-1:0]                  lo_reg;
    logic [lcr_pkg::SCALE_W-1:0]    scale_op_reg;

    logic                           last_step;
    logic [AW-1:0]                  scale_ext;
    logic [AW-1:0]                  addend;
    logic [AW-1:0]                  acc_sum;
    logic [PW-1:0]                  product;
    logic                           in_range;

    assign last_step = (step_reg == lcr_pkg::MUL_CNT_W'(lcr_pkg::MUL_STEPS - 1));
    assign scale_ext = {{(AW - lcr_pkg::SCALE_W){scale_op_reg[lcr_pkg::SCALE_W-1]}},
                        scale_op_reg};

    always_comb
    begin
        addend = '0;
        if (lo_reg[0])
        begin
            // the top multiplier bit carries negative weight
            addend = last_step ? (AW'(0) - scale_ext) : scale_ext;
        end
        acc_sum = hi_reg + addend;
    end

    assign product  = {hi_reg, lo_reg};
    assign in_range = (&product[PW-1:HI-1]) | ~(|product[PW-1:HI-1]);

    always_comb
    begin
        if (in_range)
        begin
            weight = product[HI-1:LO];
        end
        else if (product[PW-1])
        begin
            weight = {1'b1, {(lcr_pkg::WEIGHT_W-1){1'b0}}};
        end
        else
        begin
            weight = {1'b0, {(lcr_pkg::WEIGHT_W-1){1'b1}}};
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (last_step)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg       <= '0;
            lo_reg       <= diff;
            scale_op_reg <= scale;
        end
        else if (busy_reg)
        begin
            hi_reg <= {acc_sum[AW-1], acc_sum[AW-1:1]};
            lo_reg <= {acc_sum[0], lo_reg[DW-1:1]};
        end
    end

endmodule

// ----- hw/rtl/lcr_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, truncating toward zero.
module lcr_div
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [lcr_pkg::SUM_W-1:0]      dividend,
    input  logic        [lcr_pkg::SAMPLES_W-1:0]  divisor,
    output logic                                  done,
    output logic signed [lcr_pkg::SUM_W-1:0]      quotient
);

    localparam int SW = lcr_pkg::SUM_W;
    localparam int RW = lcr_pkg::SAMPLES_W;

    logic                           busy_reg;
    logic [lcr_pkg::DIV_CNT_W-1:0]  step_reg;
    logic                           done_reg;
    logic [RW-1:0]                  rem_reg;
    logic [SW-1:0]                  quo_reg;
    logic [RW-1:0]                  dvs_reg;
    logic                           neg_reg;

    logic                           last_step;
    logic [RW:0]                    partial;
    logic [RW+1:0]                  trial;
    logic                           fits;

    assign last_step = (step_reg == lcr_pkg::DIV_CNT_W'(lcr_pkg::DIV_STEPS - 1));
    assign partial   = {rem_reg, quo_reg[SW-1]};
    assign trial     = {1'b0, partial} - {2'b00, dvs_reg};
    assign fits      = ~trial[RW+1];

    assign quotient = neg_reg ? (SW'(0) - quo_reg) : quo_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (last_step)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[SW-1] ? (SW'(0) - dividend) : dividend;
            dvs_reg <= divisor;
            neg_reg <= dividend[SW-1];
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it always fits RW bits
            rem_reg <= fits ? trial[RW-1:0] : partial[RW-1:0];
            quo_reg <= {quo_reg[SW-2:0], fits};
        end
    end

endmodule

// ----- hw/rtl/loadcell_adc_serial_reader.sv -----
`timescale 1ns / 1ps

// Serial reader for a 24-bit bridge converter. Each input transfer is one timebase
// tick carrying the data pin level and a tare request; each tick returns exactly one
// output transfer with the serial clock level for that tick and any finished
// conversion or tare. A tick that ends a normal conversion waits for the 33-step
// shift-add multiplier that forms the weight; a tick that ends a tare with at least
// one valid reading waits for the 32-step restoring divider that forms the offset.
// Configuration must be written through cfg_we/cfg_index/cfg_data while no tick is
// in flight; the block itself does not enforce this.
module loadcell_adc_serial_reader
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [lcr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lcr_pkg::CFG_DATA_W-1:0]         cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   command,
    input  logic                                   dout_level,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   sck_level,
    output logic                                   sample_valid,
    output logic signed [lcr_pkg::DATA_BITS-1:0]   raw_sample,
    output logic signed [lcr_pkg::WEIGHT_W-1:0]    weight_q16,
    output logic                                   tare_done,
    output logic                                   tare_ok,
    output logic signed [lcr_pkg::DATA_BITS-1:0]   offset_value
);

    localparam int DB = lcr_pkg::DATA_BITS;
    localparam int BW = lcr_pkg::BIT_CNT_W;
    localparam int HW = lcr_pkg::HALF_W;
    localparam int WW = lcr_pkg::WAIT_W;
    localparam int NW = lcr_pkg::SAMPLES_W;
    localparam int SW = lcr_pkg::SUM_W;
    localparam int OW = lcr_pkg::OFFSET_W;
    localparam int DW = lcr_pkg::DIFF_W;

    // Configuration
    logic [lcr_pkg::GAIN_W-1:0]    gain_pulses_reg;
    logic [HW-1:0]                 half_period_reg;
    logic [WW-1:0]                 ready_timeout_reg;
    logic [NW-1:0]                 tare_samples_reg;
    logic [lcr_pkg::SCALE_W-1:0]   scale_q16_reg;

    // Tick state
    lcr_pkg::phase_t               phase_reg, phase_next;
    logic [BW-1:0]                 bit_count_reg, bit_count_next;
    logic [DB-1:0]                 shift_data_reg, shift_data_next;
    logic [HW-1:0]                 half_count_reg, half_count_next;
    logic [WW-1:0]                 wait_count_reg, wait_count_next;
    logic                          clock_out_reg, clock_out_next;
    logic                          tare_active_reg, tare_active_next;
    logic [SW-1:0]                 tare_sum_reg, tare_sum_next;
    logic [NW-1:0]                 tare_valid_reg, tare_valid_next;
    logic [NW-1:0]                 tare_taken_reg, tare_taken_next;
    logic [OW-1:0]                 tare_offset_reg;

    // Sequencer
    lcr_pkg::ctl_t                 ctl_reg, ctl_next;
    logic                          out_valid_reg;
    logic                          sck_reg;
    logic                          sample_valid_reg;
    logic [DB-1:0]                 raw_reg;
    logic [lcr_pkg::WEIGHT_W-1:0]  weight_reg;
    logic                          tare_done_reg;
    logic                          tare_ok_reg;
    logic [DB-1:0]                 offset_out_reg;

    // Per-tick working values
    logic                          accept;
    logic [HW-1:0]                 hp;
    logic [HW-1:0]                 half_inc;
    logic [BW-1:0]                 bit_inc;
    logic [BW-1:0]                 end_count;
    logic [NW-1:0]                 target;
    logic                          tare_act;
    logic [SW-1:0]                 sum_base;
    logic [NW-1:0]                 valid_base;
    logic [NW-1:0]                 taken_base;
    logic [WW-1:0]                 wait_inc;
    logic                          take_now;
    logic                          take_valid;
    logic                          res_sample;
    logic                          res_done;
    logic                          res_ok;
    logic                          need_mul;
    logic                          need_div;
    logic [DW-1:0]                 diff;

    logic                          mul_start;
    logic                          mul_done;
    logic [lcr_pkg::WEIGHT_W-1:0]  mul_weight;
    logic                          div_start;
    logic                          div_done;
    logic [SW-1:0]                 div_quotient;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (ctl_reg == lcr_pkg::CT_TICK) && (!out_valid_reg || out_ready);
    assign mul_start = accept && need_mul;
    assign div_start = accept && need_div;

    assign hp        = (half_period_reg == '0) ? HW'(1) : half_period_reg;
    assign half_inc  = half_count_reg + 1'b1;
    assign bit_inc   = bit_count_reg + 1'b1;
    assign end_count = BW'(DB) + {{(BW - lcr_pkg::GAIN_W){1'b0}}, gain_pulses_reg};
    assign target    = (tare_samples_reg == '0) ? NW'(1) : tare_samples_reg;
    assign diff      = {{(DW - DB){shift_data_reg[DB-1]}}, shift_data_reg}
                     - {{(DW - OW){tare_offset_reg[OW-1]}}, tare_offset_reg};

    // Next tick state
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_data_next  = shift_data_reg;
        half_count_next  = half_count_reg;
        wait_count_next  = wait_count_reg;
        clock_out_next   = clock_out_reg;
        tare_active_next = tare_active_reg;
        tare_sum_next    = tare_sum_reg;
        tare_valid_next  = tare_valid_reg;
        tare_taken_next  = tare_taken_reg;
        tare_act         = tare_active_reg;
        sum_base         = tare_sum_reg;
        valid_base       = tare_valid_reg;
        taken_base       = tare_taken_reg;
        wait_inc         = wait_count_reg + 1'b1;
        take_now         = 1'b0;
        take_valid       = 1'b0;
        res_sample       = 1'b0;
        res_done         = 1'b0;
        res_ok           = 1'b0;
        need_mul         = 1'b0;
        need_div         = 1'b0;

        case (phase_reg)
            lcr_pkg::PH_HIGH:
            begin
                half_count_next = half_inc;
                if (half_inc >= hp)
                begin
                    // sample on the last high tick of each data pulse
                    if (bit_count_reg < BW'(DB))
                    begin
                        shift_data_next = {shift_data_reg[DB-2:0], dout_level};
                    end
                    half_count_next = '0;
                    phase_next      = lcr_pkg::PH_LOW;
                    clock_out_next  = 1'b0;
                end
            end
            lcr_pkg::PH_LOW:
            begin
                half_count_next = half_inc;
                if (half_inc >= hp)
                begin
                    half_count_next = '0;
                    bit_count_next  = bit_inc;
                    if (bit_inc >= end_count)
                    begin
                        phase_next     = lcr_pkg::PH_IDLE;
                        bit_count_next = '0;
                        if (tare_active_reg)
                        begin
                            take_now   = 1'b1;
                            take_valid = 1'b1;
                        end
                        else
                        begin
                            res_sample = 1'b1;
                            need_mul   = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next     = lcr_pkg::PH_HIGH;
                        clock_out_next = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = lcr_pkg::PH_IDLE;
                if (command && !tare_active_reg)
                begin
                    tare_act         = 1'b1;
                    tare_active_next = 1'b1;
                    sum_base         = '0;
                    valid_base       = '0;
                    taken_base       = '0;
                    tare_sum_next    = '0;
                    tare_valid_next  = '0;
                    tare_taken_next  = '0;
                    wait_count_next  = '0;
                    wait_inc         = WW'(1);
                end
                if (!dout_level)
                begin
                    phase_next      = lcr_pkg::PH_HIGH;
                    bit_count_next  = '0;
                    shift_data_next = '0;
                    half_count_next = '0;
                    wait_count_next = '0;
                    clock_out_next  = 1'b1;
                end
                else if (tare_act)
                begin
                    wait_count_next = wait_inc;
                    if (wait_inc >= ready_timeout_reg)
                    begin
                        // reading skipped: taken but not valid
                        wait_count_next = '0;
                        take_now        = 1'b1;
                    end
                end
            end
        endcase

        if (take_now)
        begin
            tare_sum_next   = take_valid
                            ? sum_base + {{(SW - DB){shift_data_reg[DB-1]}}, shift_data_reg}
                            : sum_base;
            tare_valid_next = valid_base + NW'(take_valid);
            tare_taken_next = taken_base + 1'b1;
            if (tare_taken_next >= target)
            begin
                res_done         = 1'b1;
                tare_active_next = 1'b0;
                if (tare_valid_next != '0)
                begin
                    res_ok   = 1'b1;
                    need_div = 1'b1;
                end
            end
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= lcr_pkg::CT_TICK;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        case (ctl_reg)
            lcr_pkg::CT_TICK:
            begin
                if (mul_start)
                begin
                    ctl_next = lcr_pkg::CT_MUL;
                end
                else if (div_start)
                begin
                    ctl_next = lcr_pkg::CT_DIV;
                end
            end
            lcr_pkg::CT_MUL:
            begin
                if (mul_done)
                begin
                    ctl_next = lcr_pkg::CT_TICK;
                end
            end
            lcr_pkg::CT_DIV:
            begin
                if (div_done)
                begin
                    ctl_next = lcr_pkg::CT_TICK;
                end
            end
            default:
            begin
                ctl_next = lcr_pkg::CT_TICK;
            end
        endcase
    end

    // Configuration, tick state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_pulses_reg   <= lcr_pkg::RST_GAIN_PULSES;
            half_period_reg   <= lcr_pkg::RST_HALF_PERIOD;
            ready_timeout_reg <= lcr_pkg::RST_READY_TIMEOUT;
            tare_samples_reg  <= lcr_pkg::RST_TARE_SAMPLES;
            scale_q16_reg     <= lcr_pkg::RST_SCALE_Q16;
            phase_reg         <= lcr_pkg::PH_IDLE;
            bit_count_reg     <= '0;
            shift_data_reg    <= '0;
            half_count_reg    <= '0;
            wait_count_reg    <= '0;
            clock_out_reg     <= 1'b0;
            tare_active_reg   <= 1'b0;
            tare_sum_reg      <= '0;
            tare_valid_reg    <= '0;
            tare_taken_reg    <= '0;
            tare_offset_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lcr_pkg::REG_GAIN_PULSES:   gain_pulses_reg   <= cfg_data[lcr_pkg::GAIN_W-1:0];
                    lcr_pkg::REG_HALF_PERIOD:   half_period_reg   <= cfg_data[HW-1:0];
                    lcr_pkg::REG_READY_TIMEOUT: ready_timeout_reg <= cfg_data[WW-1:0];
                    lcr_pkg::REG_TARE_SAMPLES:  tare_samples_reg  <= cfg_data[NW-1:0];
                    lcr_pkg::REG_SCALE_Q16:     scale_q16_reg     <= cfg_data[lcr_pkg::SCALE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
            begin
                phase_reg       <= phase_next;
                bit_count_reg   <= bit_count_next;
                shift_data_reg  <= shift_data_next;
                half_count_reg  <= half_count_next;
                wait_count_reg  <= wait_count_next;
                clock_out_reg   <= clock_out_next;
                tare_active_reg <= tare_active_next;
                tare_sum_reg    <= tare_sum_next;
                tare_valid_reg  <= tare_valid_next;
                tare_taken_reg  <= tare_taken_next;
                // a result that needs arithmetic is held back until it is ready
                out_valid_reg   <= !(need_mul || need_div);
            end
            else if ((ctl_reg == lcr_pkg::CT_MUL) && mul_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if ((ctl_reg == lcr_pkg::CT_DIV) && div_done)
            begin
                out_valid_reg   <= 1'b1;
                tare_offset_reg <= div_quotient;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sck_reg          <= clock_out_reg;
            sample_valid_reg <= res_sample;
            raw_reg          <= res_sample ? shift_data_reg : '0;
            weight_reg       <= '0;
            tare_done_reg    <= res_done;
            tare_ok_reg      <= res_ok;
            offset_out_reg   <= tare_offset_reg[DB-1:0];
        end
        else if ((ctl_reg == lcr_pkg::CT_MUL) && mul_done)
        begin
            weight_reg <= mul_weight;
        end
        else if ((ctl_reg == lcr_pkg::CT_DIV) && div_done)
        begin
            offset_out_reg <= div_quotient[DB-1:0];
        end
    end

    lcr_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .scale  (scale_q16_reg),
        .diff   (diff),
        .done   (mul_done),
        .weight (mul_weight)
    );

    lcr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tare_sum_next),
        .divisor  (tare_valid_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid    = out_valid_reg;
    assign sck_level    = sck_reg;
    assign sample_valid = sample_valid_reg;
    assign raw_sample   = raw_reg;
    assign weight_q16   = weight_reg;
    assign tare_done    = tare_done_reg;
    assign tare_ok      = tare_ok_reg;
    assign offset_value = offset_out_reg;

endmodule
